FILE: rtl/core/huffman_tree_bit_decoder_core_macros.svh
// Assertion macros shared by the decoder core.
`ifndef HUFFMAN_TREE_BIT_DECODER_CORE_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_CORE_MACROS_SVH

`define HTBD_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define HTBD_ASSERT(lbl, prop) \
  `HTBD_ASSERT_MSG(lbl, clk_i, rst_ni, prop, "htbd check failed")

`endif

FILE: rtl/core/htbd_pkg.sv
package htbd_pkg;

  localparam int unsigned IdxW         = 9;
  localparam int unsigned SymW         = 8;
  localparam int unsigned CntW         = 4;
  localparam int unsigned ByteBits     = 8;
  localparam int unsigned NodeCountDef = 512;

  localparam logic ReqNode = 1'b0;
  localparam logic ReqData = 1'b1;

  typedef struct packed {
    logic [IdxW-1:0] left;
    logic [IdxW-1:0] right;
    logic            leaf;
    logic [SymW-1:0] sym;
  } node_t;

  localparam int unsigned NodeW = $bits(node_t);

  typedef struct packed {
    logic wr_node;
    logic load;
    logic step;
    logic leaf;
    logic flush;
  } htbd_cmd_t;

  typedef struct packed {
    logic nbits_zero;
    logic bits_zero;
    logic leaf_hit;
    logic pend_v;
    logic out_free;
  } htbd_sts_t;

endpackage

FILE: rtl/core/htbd_ram.sv
module htbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/htbd_ctrl.sv
module htbd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_req_type_i,
  input  htbd_pkg::htbd_sts_t sts_i,
  output logic                in_ready_o,
  output htbd_pkg::htbd_cmd_t cmd_o
);
  import htbd_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFlush
  } state_e;

  state_e state_q, state_d;
  logic   drain_ok;

  assign drain_ok   = !sts_i.pend_v || sts_i.out_free;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_req_type_i == ReqNode) begin
            cmd_o.wr_node = 1'b1;
          end else if (!sts_i.nbits_zero) begin
            cmd_o.load = 1'b1;
            state_d    = StWalk;
          end
        end
      end
      StWalk: begin
        if (sts_i.leaf_hit) begin
          if (drain_ok) begin
            cmd_o.leaf = 1'b1;
            if (sts_i.bits_zero) begin
              state_d = StFlush;
            end
          end
        end else if (sts_i.bits_zero) begin
          state_d = StFlush;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StFlush: begin
        if (drain_ok) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/htbd_dp.sv
module htbd_dp #(
  parameter int unsigned NodeCount = htbd_pkg::NodeCountDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [htbd_pkg::IdxW-1:0] cfg_wdata_i,
  input  logic [htbd_pkg::IdxW-1:0] node_index_i,
  input  logic [htbd_pkg::IdxW-1:0] left_child_i,
  input  logic [htbd_pkg::IdxW-1:0] right_child_i,
  input  logic                      is_leaf_i,
  input  logic [htbd_pkg::SymW-1:0] leaf_symbol_i,
  input  logic [htbd_pkg::SymW-1:0] data_byte_i,
  input  logic [htbd_pkg::CntW-1:0] valid_bits_i,
  input  htbd_pkg::htbd_cmd_t       cmd_i,
  output htbd_pkg::htbd_sts_t       sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [htbd_pkg::SymW-1:0] out_symbol_o,
  output logic                      out_last_o
);
  import htbd_pkg::*;

  localparam int unsigned AddrW = $clog2(NodeCount);

  logic [IdxW-1:0] root_q, cur_q, cur_d;
  logic [SymW-1:0] byte_q, pend_sym_q, out_sym_q;
  logic [CntW-1:0] bits_q, nbits_in;
  logic            test_q, oob_q, pend_v_q, out_v_q, out_last_q;
  logic            rd_en, wr_en, push, out_free;
  logic [IdxW-1:0] child, rd_idx;
  logic [NodeW-1:0] rd_data;
  node_t           entry, wr_entry;

  assign nbits_in = (valid_bits_i > CntW'(ByteBits)) ? CntW'(ByteBits) : valid_bits_i;

  assign entry = oob_q ? '0 : node_t'(rd_data);
  assign child = byte_q[ByteBits-1] ? entry.right : entry.left;

  assign rd_en  = cmd_i.load || cmd_i.step || (cmd_i.leaf && (bits_q != '0));
  assign rd_idx = cmd_i.load ? cur_q : (cmd_i.step ? child : root_q);

  assign wr_en    = cmd_i.wr_node && (int'(node_index_i) < NodeCount);
  assign wr_entry = '{left: left_child_i, right: right_child_i,
                      leaf: is_leaf_i, sym: leaf_symbol_i};

  htbd_ram #(
    .Width (NodeW),
    .Depth (NodeCount)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AddrW'(node_index_i)),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (AddrW'(rd_idx)),
    .rdata_o (rd_data)
  );

  assign out_free = !out_v_q || out_ready_i;
  assign push     = (cmd_i.leaf || cmd_i.flush) && pend_v_q;

  always_comb begin
    cur_d = cur_q;
    if (cfg_we_i || cmd_i.leaf) begin
      cur_d = cfg_we_i ? cfg_wdata_i : root_q;
    end else if (cmd_i.step) begin
      cur_d = child;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q   <= '0;
      cur_q    <= '0;
      bits_q   <= '0;
      test_q   <= 1'b0;
      oob_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      cur_q <= cur_d;
      if (rd_en) begin
        oob_q <= (int'(rd_idx) >= NodeCount);
      end
      if (cmd_i.load) begin
        bits_q <= nbits_in;
        test_q <= 1'b0;
      end else if (cmd_i.step) begin
        bits_q <= bits_q - CntW'(1);
        test_q <= 1'b1;
      end else if (cmd_i.leaf) begin
        test_q <= 1'b0;
      end
      if (cmd_i.leaf) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= data_byte_i;
    end else if (cmd_i.step) begin
      byte_q <= {byte_q[ByteBits-2:0], 1'b0};
    end
    if (cmd_i.leaf) begin
      pend_sym_q <= entry.sym;
    end
    if (push) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign sts_o.nbits_zero = (valid_bits_i == '0);
  assign sts_o.bits_zero  = (bits_q == '0);
  assign sts_o.leaf_hit   = test_q && entry.leaf;
  assign sts_o.pend_v     = pend_v_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o  = out_v_q;
  assign out_symbol_o = out_sym_q;
  assign out_last_o   = out_last_q;

endmodule

FILE: rtl/core/huffman_tree_bit_decoder_core.sv
// Channel   Direction  Payload
// s_axis    in         tuser: req_type; tdata: node write or data byte
// m_axis    out        tdata: symbol; tlast: last_of_byte
// cfg       in         root_index, written on cfg_we_i
//
// A node write or a data byte with no valid bits is taken while idle, with no walk.
// A data byte with valid bits takes a walk step per bit and a leaf step per symbol,
// all on one read port.
// Reset clears control state; node table contents are undefined until written.
// A decoded symbol waits in a pending slot until the next one or the end of the byte;
// the walk stalls only when both that slot and the output register are full.
`include "huffman_tree_bit_decoder_core_macros.svh"

module huffman_tree_bit_decoder_core #(
  parameter int unsigned NodeCount = htbd_pkg::NodeCountDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [htbd_pkg::IdxW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // node_index, left_child, right_child, is_leaf, leaf_symbol, data_byte, valid_bits
  input  logic [47:0]               s_axis_tdata,
  // req_type
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // symbol
  output logic [7:0]                m_axis_tdata,
  output logic                      m_axis_tlast
);
  import htbd_pkg::*;

  htbd_cmd_t cmd;
  htbd_sts_t sts;

  htbd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_req_type_i (s_axis_tuser),
    .sts_i         (sts),
    .in_ready_o    (s_axis_tready),
    .cmd_o         (cmd)
  );

  htbd_dp #(
    .NodeCount (NodeCount)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .node_index_i  (s_axis_tdata[8:0]),
    .left_child_i  (s_axis_tdata[17:9]),
    .right_child_i (s_axis_tdata[26:18]),
    .is_leaf_i     (s_axis_tdata[27]),
    .leaf_symbol_i (s_axis_tdata[35:28]),
    .data_byte_i   (s_axis_tdata[43:36]),
    .valid_bits_i  (s_axis_tdata[47:44]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_symbol_o  (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

  `HTBD_ASSERT(a_idle_no_pending, s_axis_tready |-> !sts.pend_v)
  `HTBD_ASSERT(a_cmd_onehot, $onehot0({cmd.wr_node, cmd.load, cmd.step, cmd.leaf, cmd.flush}))
  `HTBD_ASSERT(a_step_has_bits, cmd.step |-> !sts.bits_zero)
  `HTBD_ASSERT(a_leaf_drains, (cmd.leaf && sts.pend_v) |-> sts.out_free)

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import htbd_pkg::*;

  localparam int unsigned TableDepth   = NodeCountDef;
  localparam int unsigned RandomItems  = 420;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit   = 400000;

  typedef struct {
    logic        kind;
    logic [47:0] payload;
  } stream_req_t;

  typedef struct {
    logic [SymW-1:0] sym;
    logic            last;
  } symbol_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [IdxW-1:0]   cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // node_index, left_child, right_child, is_leaf, leaf_symbol, data_byte, valid_bits
  logic [47:0]       s_axis_tdata  = '0;
  // req_type
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // symbol
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;

  stream_req_t       req_backlog [$];
  stream_req_t       drv_req;
  symbol_t           symbols_due [$];
  symbol_t           due_sym;

  node_t             tree_mem [TableDepth];
  logic [IdxW-1:0]   root_node = '0;
  logic [IdxW-1:0]   walk_node = '0;

  bit                gen_mark [TableDepth];
  int unsigned       gen_written [$];

  logic              in_fire_q   = 1'b0;
  int unsigned       idle_pct    = 7;
  int unsigned       cycle_count = 0;
  int unsigned       mismatches  = 0;

  huffman_tree_bit_decoder_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  function automatic void walk_tree_byte(input logic [7:0] dbyte, input logic [3:0] nbits);
    int unsigned used;
    int unsigned found;
    node_t       here;
    used  = (nbits > ByteBits) ? ByteBits : nbits;
    found = 0;
    for (int unsigned b = 0; b < used; b++) begin
      here      = tree_mem[walk_node];
      walk_node = dbyte[7 - b] ? here.right : here.left;
      if (tree_mem[walk_node].leaf) begin
        symbols_due.push_back('{sym: tree_mem[walk_node].sym, last: 1'b0});
        found++;
        walk_node = root_node;
      end
    end
    if (found != 0) begin
      symbols_due[symbols_due.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void absorb_request(input logic kind, input logic [47:0] p);
    if (kind == ReqNode) begin
      tree_mem[p[8:0]] = '{left: p[17:9], right: p[26:18], leaf: p[27], sym: p[35:28]};
    end else begin
      walk_tree_byte(p[43:36], p[47:44]);
    end
  endfunction

  function automatic void queue_node(input int unsigned idx, input int unsigned lchild,
                                     input int unsigned rchild, input logic leaf,
                                     input int unsigned sym);
    logic [47:0] p;
    p = {4'($urandom), 8'($urandom), 8'(sym), leaf, 9'(rchild), 9'(lchild), 9'(idx)};
    req_backlog.push_back('{kind: ReqNode, payload: p});
    if (!gen_mark[idx]) begin
      gen_mark[idx] = 1'b1;
      gen_written.push_back(idx);
    end
  endfunction

  function automatic void queue_byte(input int unsigned dbyte, input int unsigned nbits);
    logic [47:0] p;
    p = {4'(nbits), 8'(dbyte), 4'($urandom), 32'($urandom)};
    req_backlog.push_back('{kind: ReqData, payload: p});
  endfunction

  // Leaves are written first, then inner nodes that merge two random subtrees.
  // Every child field points inside the new tree, so no walk can reach an
  // entry that was never written.
  function automatic int unsigned build_tree(input int unsigned leaves, input int forced);
    bit          taken [TableDepth];
    int unsigned nodes [$];
    int unsigned pool [$];
    int unsigned idx, a, b, pos, span;
    span = 2 * leaves - 1;
    if (forced >= 0) begin
      taken[forced] = 1'b1;
    end
    for (int unsigned i = 0; i < span; i++) begin
      if (forced >= 0 && i == span - 1) begin
        idx = forced;
      end else begin
        do idx = $urandom_range(TableDepth - 1); while (taken[idx]);
      end
      taken[idx] = 1'b1;
      nodes.push_back(idx);
    end
    for (int unsigned i = 0; i < leaves; i++) begin
      queue_node(nodes[i], nodes[$urandom_range(span - 1)], nodes[$urandom_range(span - 1)],
                 1'b1, $urandom_range(255));
      pool.push_back(nodes[i]);
    end
    for (int unsigned i = leaves; i < span; i++) begin
      pos = $urandom_range(pool.size() - 1);
      a   = pool[pos];
      pool.delete(pos);
      pos = $urandom_range(pool.size() - 1);
      b   = pool[pos];
      pool.delete(pos);
      queue_node(nodes[i], a, b, 1'b0, $urandom_range(255));
      pool.push_back(nodes[i]);
    end
    return nodes[span - 1];
  endfunction

  task automatic wait_quiet();
    while (req_backlog.size() != 0 || s_axis_tvalid || symbols_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_root(input logic [IdxW-1:0] idx);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= idx;
    root_node    = idx;
    walk_node    = idx;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
      if (!s_axis_tvalid || in_fire_q) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drv_req = req_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drv_req.payload;
          s_axis_tuser  <= drv_req.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      in_fire_q <= s_axis_tvalid && s_axis_tready;
      if (rst_ni && s_axis_tvalid && s_axis_tready) begin
        absorb_request(s_axis_tuser, s_axis_tdata);
      end
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (symbols_due.size() == 0) begin
          report_mismatch("symbol with nothing due", m_axis_tdata, 0);
        end else begin
          due_sym = symbols_due.pop_front();
          if (m_axis_tdata !== due_sym.sym) begin
            report_mismatch("symbol", m_axis_tdata, due_sym.sym);
          end
          if (m_axis_tlast !== due_sym.last) begin
            report_mismatch("last_of_byte", m_axis_tlast, due_sym.last);
          end
        end
      end
    end
  end

  initial begin
    int unsigned k, root, nitems, issued, phase;
    int          forced;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Codes: 0 gives 8'hFF, 10 gives 8'h00, 11 gives 8'h5A.
    queue_node(0, 511, 1, 1'b0, 8'h00);
    queue_node(511, 0, 511, 1'b1, 8'hFF);
    queue_node(1, 2, 3, 1'b0, 8'hFF);
    queue_node(2, 0, 0, 1'b1, 8'h00);
    queue_node(3, 511, 511, 1'b1, 8'h5A);
    queue_byte(8'h00, 8);
    queue_byte(8'hFF, 8);
    queue_byte(8'hA5, 4);
    queue_byte(8'h5A, 0);
    queue_byte(8'h3C, 15);
    queue_byte(8'h80, 1);
    // The walk is parked on an inner node while a leaf below it is rewritten.
    queue_node(3, 511, 511, 1'b1, 8'h3C);
    queue_byte(8'hC0, 1);
    queue_byte(8'hFF, 7);
    // With a leaf as the root, the walk still steps to its children first.
    set_root(511);
    queue_byte(8'h55, 8);
    queue_byte(8'hB6, 8);
    set_root(0);

    issued = 0;
    phase  = 0;
    while (issued < RandomItems) begin
      k      = ($urandom_range(7) == 0) ? $urandom_range(12, 32) : $urandom_range(2, 8);
      forced = (phase == 0) ? 511 : (phase == 1) ? 0 : -1;
      root   = build_tree(k, forced);
      issued += 2 * k - 1;
      if (phase > 1 && $urandom_range(7) == 0) begin
        root = gen_written[$urandom_range(gen_written.size() - 1)];
      end
      set_root(IdxW'(root));
      idle_pct = (phase == 2) ? 0 : 7;
      nitems   = (phase == 2) ? 60 : $urandom_range(8, 30);
      for (int unsigned j = 0; j < nitems; j++) begin
        if ($urandom_range(99) < 15) begin
          queue_node(gen_written[$urandom_range(gen_written.size() - 1)],
                     gen_written[$urandom_range(gen_written.size() - 1)],
                     gen_written[$urandom_range(gen_written.size() - 1)],
                     1'($urandom), $urandom_range(255));
        end else begin
          queue_byte($urandom_range(255),
                     ($urandom_range(3) != 0) ? 8 : $urandom_range(15));
        end
      end
      issued += nitems;
      phase++;
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
